// ===== hdl/pwq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwq_pkg
// Shared widths, register indexes and the lane-to-merge event bundle of the
// pulse width qualifier.
// ---------------------------------------------------------------------------
package pwq_pkg;

    // Field widths
    localparam int PIN_W     = 22;
    localparam int COIN_W    = 8;
    localparam int CASH_W    = 6;
    localparam int SIG_W     = 8;
    localparam int LEN_W     = 32;
    localparam int CFG_IDX_W = 8;

    // Default channel layout
    localparam int DEF_POSTS        = 6;
    localparam int DEF_VACUUM_UNITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COIN_MIN_LEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CASH_MIN_LEN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CASH_HOLD_LEN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MIN_LEN = CFG_IDX_W'(3);

    // Edge events found by the lanes for one sample
    typedef struct packed {
        logic [COIN_W-1:0] coin_rise;
        logic [CASH_W-1:0] cash_fall;
        logic [CASH_W-1:0] cash_rise;
        logic [SIG_W-1:0]  sig_fall;
        logic [SIG_W-1:0]  sig_rise;
    } t_edges;

endpackage
`default_nettype wire

// ===== hdl/pwq_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwq_lane
// One pin channel: edge detection, start time capture and low-pulse
// length qualification against a threshold.
// ---------------------------------------------------------------------------
module pwq_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_pin,
    input  wire logic                      i_prev_pin,
    input  wire logic [pwq_pkg::LEN_W-1:0] i_ticks,
    input  wire logic [pwq_pkg::LEN_W-1:0] i_min_len,
    output logic                           o_fall,
    output logic                           o_rise_ok
);
    import pwq_pkg::*;

    logic [LEN_W-1:0] r_start;
    logic [LEN_W-1:0] n_start;
    logic [LEN_W-1:0] w_len;

    // Edge decode and wrapping length
    always_comb begin
        o_fall    = i_prev_pin & ~i_pin;
        w_len     = i_ticks - r_start;
        o_rise_ok = ~i_prev_pin & i_pin & (w_len > i_min_len);
        n_start   = (i_en && o_fall) ? i_ticks : r_start;
    end

    // Start time of the current low pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else begin
            r_start <= n_start;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pwq_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pwq_merge
// Combines lane events: validator pending marks with hold-off commit,
// sticky signal flags, and the registered result transfer.
// ---------------------------------------------------------------------------
module pwq_merge (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire pwq_pkg::t_edges            i_edges,
    input  wire logic [pwq_pkg::LEN_W-1:0]  i_os_time,
    input  wire logic [pwq_pkg::LEN_W-1:0]  i_hold_len,
    input  wire logic [pwq_pkg::SIG_W-1:0]  i_ack,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [pwq_pkg::COIN_W-1:0]      o_coin_pulses,
    output logic [pwq_pkg::CASH_W-1:0]      o_cash_commits,
    output logic [pwq_pkg::SIG_W-1:0]       o_signal_pending
);
    import pwq_pkg::*;

    logic [CASH_W-1:0] r_pending;
    logic [CASH_W-1:0] n_pending;
    logic [LEN_W-1:0]  r_stamp [CASH_W];
    logic [SIG_W-1:0]  r_flags;
    logic [SIG_W-1:0]  n_flags;
    logic [CASH_W-1:0] w_commit;
    logic              r_out_valid;
    logic [COIN_W-1:0] r_coin;
    logic [CASH_W-1:0] r_commit;
    logic [SIG_W-1:0]  r_sig;

    // Commit check first, then validator and signal edges
    always_comb begin
        for (int c = 0; c < CASH_W; c++) begin
            w_commit[c] = r_pending[c] && ((i_os_time - r_stamp[c]) > i_hold_len);
        end
        n_pending = (r_pending & ~w_commit & ~i_edges.cash_fall) | i_edges.cash_rise;
        n_flags   = (r_flags & ~i_ack & ~i_edges.sig_fall) | i_edges.sig_rise;
    end

    // Per-sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_flags   <= '0;
            for (int c = 0; c < CASH_W; c++) begin
                r_stamp[c] <= '0;
            end
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_flags   <= n_flags;
            for (int c = 0; c < CASH_W; c++) begin
                if (i_edges.cash_rise[c]) begin
                    r_stamp[c] <= i_os_time;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_coin   <= i_edges.coin_rise;
            r_commit <= w_commit;
            r_sig    <= n_flags;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coin_pulses    = r_coin;
    assign o_cash_commits   = r_commit;
    assign o_signal_pending = r_sig;

endmodule
`default_nettype wire

// ===== hdl/multi_channel_pulse_width_qualifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multi_channel_pulse_width_qualifier
// Qualifies low pulses on coin, bill validator and signal pins; one
// result per pin sample.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//   in      | in        | i_in_valid / o_in_ready    | pins, os tick, signal ack
//   out     | out       | o_out_valid / i_out_ready  | coin, commit, pending bits
//
// One sample per clock unless the output stalls; its result appears in the
// cycle after the transfer. All lanes compare their pulse length in parallel
// in the accept cycle, and the merge stage registers the result.
// Input is ready whenever the result register is empty or being taken.
// Synchronous reset; no clearing pass. Config is always ready.
// ---------------------------------------------------------------------------
module multi_channel_pulse_width_qualifier #(
    parameter int POSTS        = pwq_pkg::DEF_POSTS,
    parameter int VACUUM_UNITS = pwq_pkg::DEF_VACUUM_UNITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pwq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pwq_pkg::LEN_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [pwq_pkg::PIN_W-1:0]     i_pin_levels,
    input  wire logic                          i_os_tick,
    input  wire logic [pwq_pkg::SIG_W-1:0]     i_signal_ack,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [pwq_pkg::COIN_W-1:0]         o_coin_pulses,
    output logic [pwq_pkg::CASH_W-1:0]         o_cash_commits,
    output logic [pwq_pkg::SIG_W-1:0]          o_signal_pending
);
    import pwq_pkg::*;

    logic [LEN_W-1:0] r_coin_min;
    logic [LEN_W-1:0] r_cash_min;
    logic [LEN_W-1:0] r_cash_hold;
    logic [LEN_W-1:0] r_sig_min;
    logic [LEN_W-1:0] r_ticks;
    logic [LEN_W-1:0] n_ticks;
    logic [LEN_W-1:0] r_os_time;
    logic [LEN_W-1:0] n_os_time;
    logic [PIN_W-1:0] r_prev_pins;
    logic             w_accept;
    t_edges           w_edges;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_min  <= '0;
            r_cash_min  <= '0;
            r_cash_hold <= '0;
            r_sig_min   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_COIN_MIN_LEN)   r_coin_min  <= i_cfg_data;
            if (i_cfg_index == REG_CASH_MIN_LEN)   r_cash_min  <= i_cfg_data;
            if (i_cfg_index == REG_CASH_HOLD_LEN)  r_cash_hold <= i_cfg_data;
            if (i_cfg_index == REG_SIGNAL_MIN_LEN) r_sig_min   <= i_cfg_data;
        end
    end

    // Input transfer
    assign o_in_ready = ~o_out_valid | i_out_ready;
    assign w_accept   = i_in_valid & o_in_ready;

    // Sample counter, OS time and previous pin levels
    assign n_ticks   = r_ticks + LEN_W'(1);
    assign n_os_time = r_os_time + LEN_W'(i_os_tick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= '0;
            r_os_time   <= '0;
            r_prev_pins <= '1;
        end else if (w_accept) begin
            r_ticks     <= n_ticks;
            r_os_time   <= n_os_time;
            r_prev_pins <= i_pin_levels;
        end
    end

    // Coin and signal lanes: posts first, then vacuum units
    for (genvar c = 0; c < COIN_W; c++) begin : g_ch
        localparam int CoinPos = (c < POSTS) ? 3 * c + 1 : 3 * POSTS + 2 * (c - POSTS);
        localparam int SigPos  = CoinPos + 1;
        localparam bit ChOn    = (c < POSTS + VACUUM_UNITS);

        if (ChOn && CoinPos < PIN_W) begin : g_coin
            logic w_fall;
            pwq_lane u_coin (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_accept),
                .i_pin      (i_pin_levels[CoinPos]),
                .i_prev_pin (r_prev_pins[CoinPos]),
                .i_ticks    (n_ticks),
                .i_min_len  (r_coin_min),
                .o_fall     (w_fall),
                .o_rise_ok  (w_edges.coin_rise[c])
            );
        end else begin : g_no_coin
            assign w_edges.coin_rise[c] = 1'b0;
        end

        if (ChOn && SigPos < PIN_W && c < SIG_W) begin : g_sig
            pwq_lane u_sig (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_accept),
                .i_pin      (i_pin_levels[SigPos]),
                .i_prev_pin (r_prev_pins[SigPos]),
                .i_ticks    (n_ticks),
                .i_min_len  (r_sig_min),
                .o_fall     (w_edges.sig_fall[c]),
                .o_rise_ok  (w_edges.sig_rise[c])
            );
        end else begin : g_no_sig
            assign w_edges.sig_fall[c] = 1'b0;
            assign w_edges.sig_rise[c] = 1'b0;
        end
    end

    // Validator lanes, one per post
    for (genvar p = 0; p < CASH_W; p++) begin : g_cash
        localparam int CashPos = 3 * p;

        if (p < POSTS && CashPos < PIN_W) begin : g_on
            pwq_lane u_cash (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_accept),
                .i_pin      (i_pin_levels[CashPos]),
                .i_prev_pin (r_prev_pins[CashPos]),
                .i_ticks    (n_ticks),
                .i_min_len  (r_cash_min),
                .o_fall     (w_edges.cash_fall[p]),
                .o_rise_ok  (w_edges.cash_rise[p])
            );
        end else begin : g_off
            assign w_edges.cash_fall[p] = 1'b0;
            assign w_edges.cash_rise[p] = 1'b0;
        end
    end

    // Merge stage and result register
    pwq_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_edges          (w_edges),
        .i_os_time        (n_os_time),
        .i_hold_len       (r_cash_hold),
        .i_ack            (i_signal_ack),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_coin_pulses    (o_coin_pulses),
        .o_cash_commits   (o_cash_commits),
        .o_signal_pending (o_signal_pending)
    );

endmodule
`default_nettype wire

// ===== sim/multi_channel_pulse_width_qualifier_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_channel_pulse_width_qualifier_tb
// Drives pin samples through the pulse width qualifier and checks every
// result against a cycle-free model of the coin, bill validator and signal
// channels held in a scoreboard. Covers register extremes, edge ordering
// cases and random pin activity under sender and receiver stalls.
// ---------------------------------------------------------------------------
module multi_channel_pulse_width_qualifier_tb;
    import pwq_pkg::*;

    localparam int POSTS         = DEF_POSTS;
    localparam int CHANNELS      = DEF_POSTS + DEF_VACUUM_UNITS;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 235;

    // Register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX      = {CFG_IDX_W{1'b1}};

    // Pin groups (active low)
    localparam logic [PIN_W-1:0] ALL_PINS  = {PIN_W{1'b1}};
    localparam logic [PIN_W-1:0] CASH_PINS = PIN_W'(22'h009249);
    localparam logic [PIN_W-1:0] COIN_PINS = PIN_W'(22'h152492);
    localparam logic [PIN_W-1:0] SIG_PINS  = PIN_W'(22'h2A4924);
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

    typedef struct {
        logic [COIN_W-1:0] coins;
        logic [CASH_W-1:0] commits;
        logic [SIG_W-1:0]  pending;
    } sample_result_t;

    // Scoreboard: channel model plus the queue of results still due
    class pulse_scoreboard;
        logic [LEN_W-1:0]  coin_min, cash_min, cash_hold, sig_min;
        logic [LEN_W-1:0]  sample_count, os_count;
        logic [PIN_W-1:0]  last_pins;
        logic [LEN_W-1:0]  cash_fall_at[CASH_W];
        logic [LEN_W-1:0]  cash_armed_at[CASH_W];
        logic [LEN_W-1:0]  coin_fall_at[COIN_W];
        logic [LEN_W-1:0]  sig_fall_at[SIG_W];
        logic [CASH_W-1:0] cash_armed;
        logic [SIG_W-1:0]  sig_flags;
        sample_result_t    due_results[$];
        int                errors;

        function new();
            coin_min = '0; cash_min = '0; cash_hold = '0; sig_min = '0;
            sample_count = '0; os_count = '0;
            last_pins = ALL_PINS;
            for (int i = 0; i < CASH_W; i++) begin
                cash_fall_at[i] = '0;
                cash_armed_at[i] = '0;
            end
            for (int i = 0; i < COIN_W; i++) begin
                coin_fall_at[i] = '0;
                sig_fall_at[i] = '0;
            end
            cash_armed = '0;
            sig_flags = '0;
            errors = 0;
        endfunction

        function int waiting();
            return due_results.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
            case (idx)
                REG_COIN_MIN_LEN:   coin_min = data;
                REG_CASH_MIN_LEN:   cash_min = data;
                REG_CASH_HOLD_LEN:  cash_hold = data;
                REG_SIGNAL_MIN_LEN: sig_min = data;
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted sample and queue its result
        function void take_sample(logic [PIN_W-1:0] pins, logic tick, logic [SIG_W-1:0] ack);
            logic [PIN_W-1:0] changed;
            sample_result_t   r;
            int               cash_pos, coin_pos, sig_pos;
            r.coins = '0;
            r.commits = '0;
            sample_count = sample_count + 1'b1;
            if (tick) os_count = os_count + 1'b1;
            // ack goes first, so a same-sample rise still sets the flag
            sig_flags &= ~ack;
            // aged validator marks commit before edges are seen
            for (int c = 0; c < POSTS && c < CASH_W; c++) begin
                if (cash_armed[c] && (os_count - cash_armed_at[c]) > cash_hold) begin
                    cash_armed[c] = 1'b0;
                    r.commits[c] = 1'b1;
                end
            end
            changed = pins ^ last_pins;
            last_pins = pins;
            for (int c = 0; c < CHANNELS && c < COIN_W; c++) begin
                if (c < POSTS) begin
                    cash_pos = 3 * c;
                    coin_pos = 3 * c + 1;
                    sig_pos = 3 * c + 2;
                    if (c < CASH_W && cash_pos < PIN_W && changed[cash_pos]) begin
                        if (!pins[cash_pos]) begin
                            cash_fall_at[c] = sample_count;
                            cash_armed[c] = 1'b0;
                        end else if ((sample_count - cash_fall_at[c]) > cash_min) begin
                            cash_armed[c] = 1'b1;
                            cash_armed_at[c] = os_count;
                        end
                    end
                end else begin
                    coin_pos = 3 * POSTS + 2 * (c - POSTS);
                    sig_pos = coin_pos + 1;
                end
                if (coin_pos < PIN_W && changed[coin_pos]) begin
                    if (!pins[coin_pos]) coin_fall_at[c] = sample_count;
                    else if ((sample_count - coin_fall_at[c]) > coin_min) r.coins[c] = 1'b1;
                end
                if (sig_pos < PIN_W && changed[sig_pos]) begin
                    if (!pins[sig_pos]) begin
                        sig_fall_at[c] = sample_count;
                        sig_flags[c] = 1'b0;
                    end else if ((sample_count - sig_fall_at[c]) > sig_min) begin
                        sig_flags[c] = 1'b1;
                    end
                end
            end
            r.pending = sig_flags;
            due_results.push_back(r);
        endfunction

        // One line per mismatch, and a running count
        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [COIN_W-1:0] coins, logic [CASH_W-1:0] commits,
                          logic [SIG_W-1:0] pending);
            sample_result_t r;
            if (due_results.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                r = due_results.pop_front();
                if (coins !== r.coins)
                    report($sformatf("coin_pulses %h, expected %h", coins, r.coins));
                if (commits !== r.commits)
                    report($sformatf("cash_commits %h, expected %h", commits, r.commits));
                if (pending !== r.pending)
                    report($sformatf("signal_pending %h, expected %h", pending, r.pending));
            end
        endtask

        task flag_leftovers();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEN_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [PIN_W-1:0]     i_pin_levels;
    logic                 i_os_tick;
    logic [SIG_W-1:0]     i_signal_ack;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [COIN_W-1:0]    o_coin_pulses;
    logic [CASH_W-1:0]    o_cash_commits;
    logic [SIG_W-1:0]     o_signal_pending;

    pulse_scoreboard  score = new();
    int               send_idle_pct;
    int               recv_stall_pct;
    int               quiet_cycles;
    logic             moved;
    logic [PIN_W-1:0] pin_state;

    multi_channel_pulse_width_qualifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pin_levels    (i_pin_levels),
        .i_os_tick       (i_os_tick),
        .i_signal_ack    (i_signal_ack),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_coin_pulses   (o_coin_pulses),
        .o_cash_commits  (o_cash_commits),
        .o_signal_pending(o_signal_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall per cycle
    always @(negedge i_clk) begin
        i_out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                score.check_result(o_coin_pulses, o_cash_commits, o_signal_pending);
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                score.take_sample(i_pin_levels, i_os_tick, i_signal_ack);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                score.set_register(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // One sample transfer; valid stays up straight into the next item
    task automatic send_sample(logic [PIN_W-1:0] pins, logic tick, logic [SIG_W-1:0] ack);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pin_levels = pins;
        i_os_tick = tick;
        i_signal_ack = ack;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait for every result to come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (score.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random pin activity: levels toggle at a rate of 1/toggle_den per pin,
    // with occasional fully random samples as noise
    task automatic run_phase(logic [LEN_W-1:0] coin, logic [LEN_W-1:0] cash,
                             logic [LEN_W-1:0] hold, logic [LEN_W-1:0] sig,
                             int send_pct, int stall_pct, int toggle_den);
        logic [PIN_W-1:0] flip;
        logic [SIG_W-1:0] ack;
        write_reg(REG_COIN_MIN_LEN, coin);
        write_reg(REG_CASH_MIN_LEN, cash);
        write_reg(REG_CASH_HOLD_LEN, hold);
        write_reg(REG_SIGNAL_MIN_LEN, sig);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(19) == 0) begin
                pin_state = PIN_W'($urandom);
            end else begin
                flip = '0;
                for (int b = 0; b < PIN_W; b++)
                    flip[b] = ($urandom_range(toggle_den - 1) == 0);
                pin_state = pin_state ^ flip;
            end
            ack = ($urandom_range(3) == 0) ? SIG_W'($urandom) : '0;
            send_sample(pin_state, ($urandom_range(9) < 4), ack);
            // hold the sender until the pipeline is empty once per phase
            if (n == PHASE_ITEMS / 2) drain_results();
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pin_levels = ALL_PINS;
        i_os_tick = 1'b0;
        i_signal_ack = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        pin_state = ALL_PINS;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers at reset: every completed pulse qualifies
        send_sample(ALL_PINS, 1'b0, '0);
        send_sample('0, 1'b1, {SIG_W{1'b1}});
        send_sample(ALL_PINS, 1'b1, {SIG_W{1'b1}});    // ack then rise: flags set
        send_sample(ALL_PINS, 1'b1, '0);               // armed validators commit
        send_sample(ALL_PINS & ~SIG_PINS, 1'b0, '0);   // signal fall clears flags
        send_sample(ALL_PINS, 1'b0, '0);
        send_sample(ALL_PINS, 1'b0, {SIG_W{1'b1}});
        drain_results();

        // Writes to unmapped indexes are dropped
        write_reg(REG_FIRST_UNMAPPED, LEN_MAX);
        write_reg(REG_TOP_INDEX, LEN_MAX);
        write_reg(REG_COIN_MIN_LEN, 2);
        write_reg(REG_CASH_MIN_LEN, 3);
        write_reg(REG_CASH_HOLD_LEN, 1);
        write_reg(REG_SIGNAL_MIN_LEN, 2);

        // Four-sample pulse on every pin, then validator disarm
        send_sample('0, 1'b0, '0);
        send_sample('0, 1'b1, '0);
        send_sample('0, 1'b0, '0);
        send_sample('0, 1'b1, '0);
        send_sample(ALL_PINS, 1'b1, SIG_W'(8'h55));
        send_sample(ALL_PINS & ~CASH_PINS, 1'b0, '0);  // fall disarms the mark
        send_sample(ALL_PINS, 1'b1, '0);               // too short to arm
        send_sample(ALL_PINS, 1'b1, '0);
        // Short coin and signal pulses stay below threshold
        send_sample(ALL_PINS & ~COIN_PINS, 1'b0, '0);
        send_sample(ALL_PINS, 1'b0, '0);
        send_sample(ALL_PINS & ~SIG_PINS, 1'b1, '0);
        send_sample(ALL_PINS & ~SIG_PINS, 1'b0, '0);
        send_sample(ALL_PINS, 1'b1, '0);
        send_sample(PIN_W'(22'h155555), 1'b1, SIG_W'(8'hAA));
        send_sample(PIN_W'(22'h2AAAAA), 1'b0, SIG_W'(8'h55));
        drain_results();

        // Random phases over idling modes and register settings
        run_phase(2, 3, 1, 2, 0, 0, 6);
        run_phase('0, '0, '0, '0, 61, 0, 4);
        run_phase(5, 8, 3, 6, 0, 61, 10);
        run_phase(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, 38, 38, 5);
        run_phase(1, 2, 2, LEN_MAX, 0, 0, 3);
        run_phase($urandom_range(8), $urandom_range(8), $urandom_range(4),
                  $urandom_range(8), 61, 0, 8);
        run_phase(LEN_MAX, '0, '0, 3, 0, 61, 6);
        run_phase($urandom_range(8), $urandom_range(8), $urandom_range(4),
                  $urandom_range(8), 38, 38, 6);

        score.flag_leftovers();
        if (score.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
